// ===== rtl/slps_pkg.sv =====
// slps_pkg: shared types, mode codes and timing constants for the status LED
// pattern sequencer. No dependencies; imported by every rtl module of the block.
`default_nettype none
package slps_pkg;

   // display mode codes (codes 6 and 7 behave like init)
   localparam logic [2:0] MODE_INIT      = 3'd0;
   localparam logic [2:0] MODE_CHECK     = 3'd1;
   localparam logic [2:0] MODE_UPGRADING = 3'd2;
   localparam logic [2:0] MODE_DONE      = 3'd3;
   localparam logic [2:0] MODE_JUMP      = 3'd4;
   localparam logic [2:0] MODE_ERROR     = 3'd5;

   // action codes
   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_SET  = 1'b1;

   // timer limits
   localparam logic [10:0] PHASE_MAX  = 11'd2047;
   localparam logic [8:0]  TOGGLE_MAX = 9'd511;

   // blink timing in ms
   localparam logic [10:0] CHECK_ON_MS     = 11'd250;
   localparam logic [10:0] CHECK_CYCLE_MS  = 11'd500;
   localparam logic [10:0] UPGRADE_ON_MS    = 11'd100;
   localparam logic [10:0] UPGRADE_CYCLE_MS = 11'd200;

   // sos timing in ms
   localparam logic [10:0] SOS_DOT_MS      = 11'd200;
   localparam logic [10:0] SOS_DASH_MS     = 11'd600;
   localparam logic [10:0] SOS_GAP_MS      = 11'd200;
   localparam logic [10:0] SOS_LETTER_GAP_MS = 11'd600;
   localparam logic [10:0] SOS_WORD_GAP_MS = 11'd2000;
   localparam logic [3:0]  SOS_LAST_POS    = 4'd8;
   localparam logic [3:0]  SOS_POS_C       = 4'd2;
   localparam logic [3:0]  SOS_POS_F       = 4'd5;

   // error mode led0 toggle periods in ms
   localparam logic signed [7:0] ERR_CODE_FAST = -8'sd4;
   localparam logic [8:0] TOGGLE_FAST_MS = 9'd200;
   localparam logic [8:0] TOGGLE_SLOW_MS = 9'd500;

   typedef struct packed {
      logic       action;
      logic [2:0] mode;
   } req_type;

   typedef struct packed {
      logic led0_lit;
      logic led1_lit;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  current_mode;
      logic [10:0] phase_elapsed;
      logic [8:0]  toggle_elapsed;
      logic [3:0]  sos_position;
      logic        sos_lit_phase;
      logic        led0_level;
      logic        led1_level;
   } state_type;

   // elements 3 to 5 of the sos sequence are dashes
   function automatic logic sos_is_dash(input logic [3:0] pos);
      logic dash;
      case (pos) inside
         [4'd3:4'd5]: dash = 1'b1;
         default:     dash = 1'b0;
      endcase
      return dash;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/status_led_pattern_sequencer.sv =====
// status_led_pattern_sequencer: top level with input stage, pattern state,
// result register and error code register. Depends on slps_pkg and slps_step.
//
// usage
//  - req channel: one beat per event, action tick (1 ms elapsed) or set (new
//    display mode in mode). every req beat yields exactly one rsp beat.
//  - rsp channel: led0_lit / led1_lit, the led levels after that event.
//  - csr port: csr_write_enable writes csr_write_data into the signed error
//    code; -4 selects the fast 200 ms led0 toggle in error mode. write it
//    only while no beat is in flight.
//  - path: a req beat taken from the channel is registered in the input
//    stage, evaluated against the pattern state and then lands in the rsp
//    register, which drives rsp_valid.
//  - throughput: one beat per cycle while rsp_stall is low; the input register,
//    the combinational next-state logic and the rsp register form a two-stage pipeline.
//  - stall: while rsp_stall holds a result, the input stage still takes
//    one more beat; req_stall rises only once both stages are full.
//  - reset: synchronous, active high. mode returns to init, timers to zero,
//    both leds off, error code to 0, both pipeline stages empty.
`default_nettype none
module status_led_pattern_sequencer import slps_pkg::*; (
   input  var logic             clock,
   input  var logic             reset,
   input  var logic             req_valid,
   output logic                 req_stall,
   input  var req_type          req_payload,
   output logic                 rsp_valid,
   input  var logic             rsp_stall,
   output rsp_type              rsp_payload,
   input  var logic             csr_write_enable,
   input  var logic signed [7:0] csr_write_data
);

   // input stage
   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_beat_ff;

   // pattern state and result register
   state_type state_ff;
   state_type state_in;
   logic      out_valid_ff;
   logic      out_valid_in;
   rsp_type   out_beat_ff;

   logic signed [7:0] error_code_ff;

   logic out_free;   // rsp register can take a beat this cycle
   logic step_fire;  // input stage moves into the rsp register
   logic req_take;

   assign out_free  = ~out_valid_ff | ~rsp_stall;
   assign step_fire = in_valid_ff & out_free;
   assign req_stall = in_valid_ff & ~out_free;
   assign req_take  = req_valid & ~req_stall;

   assign in_valid_in  = req_take | (in_valid_ff & ~step_fire);
   assign out_valid_in = step_fire | (out_valid_ff & rsp_stall);

   slps_step u_step (
      .state_cur  (state_ff),
      .req        (in_beat_ff),
      .error_code (error_code_ff),
      .state_nxt  (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         error_code_ff <= '0;
         state_ff      <= '{current_mode: MODE_INIT, phase_elapsed: '0,
                            toggle_elapsed: '0, sos_position: '0,
                            sos_lit_phase: 1'b1, led0_level: 1'b0,
                            led1_level: 1'b0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            error_code_ff <= csr_write_data;
         end
         // state only advances when the beat's result has a place to go
         if (step_fire) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_beat_ff <= req_payload;
      end
      if (step_fire) begin
         out_beat_ff <= '{led0_lit: state_in.led0_level, led1_lit: state_in.led1_level};
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_beat_ff;

   // sos position never leaves the nine-element sequence
   a_sos_pos_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.sos_position <= SOS_LAST_POS)
      else $error("sos position out of range");

   // a set beat clears both timers and darkens both leds
   a_set_clears: assert property (@(posedge clock) disable iff (reset)
      (step_fire && in_beat_ff.action == ACT_SET) |=>
      (state_ff.phase_elapsed == '0 && state_ff.toggle_elapsed == '0 &&
       !rsp_payload.led0_lit && !rsp_payload.led1_lit))
      else $error("set beat did not restart pattern");

   // a tick in jump mode yields dark leds
   a_jump_dark: assert property (@(posedge clock) disable iff (reset)
      (step_fire && in_beat_ff.action == ACT_TICK && state_ff.current_mode == MODE_JUMP)
      |=> (rsp_valid && !rsp_payload.led0_lit && !rsp_payload.led1_lit))
      else $error("jump mode lit an led");

   // a held input beat keeps its payload until it moves on
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !step_fire) |=> (in_valid_ff && $stable(in_beat_ff)))
      else $error("input stage lost a beat");

endmodule
`default_nettype wire

// ===== rtl/slps_step.sv =====
// slps_step: combinational next-state logic for one input beat.
// Depends on slps_pkg.
`default_nettype none
module slps_step import slps_pkg::*; (
   input  var state_type        state_cur,
   input  var req_type          req,
   input  var logic signed [7:0] error_code,
   output state_type            state_nxt
);

   logic [10:0] phase_inc;
   logic [8:0]  toggle_inc;
   logic [10:0] on_ms;
   logic [10:0] cycle_ms;
   logic [10:0] lit_ms;
   logic [10:0] gap_ms;
   logic [8:0]  period_ms;
   state_type   sos_st;

   // saturating timers
   assign phase_inc  = (state_cur.phase_elapsed < PHASE_MAX) ?
                       11'(state_cur.phase_elapsed + 11'd1) : state_cur.phase_elapsed;
   assign toggle_inc = (state_cur.toggle_elapsed < TOGGLE_MAX) ?
                       9'(state_cur.toggle_elapsed + 9'd1) : state_cur.toggle_elapsed;

   assign on_ms    = (state_cur.current_mode == MODE_CHECK) ? CHECK_ON_MS : UPGRADE_ON_MS;
   assign cycle_ms = (state_cur.current_mode == MODE_CHECK) ? CHECK_CYCLE_MS
                                                            : UPGRADE_CYCLE_MS;

   assign lit_ms = sos_is_dash(state_cur.sos_position) ? SOS_DASH_MS : SOS_DOT_MS;

   always_comb begin
      if (state_cur.sos_position == SOS_POS_C || state_cur.sos_position == SOS_POS_F) begin
         gap_ms = SOS_LETTER_GAP_MS;
      end else if (state_cur.sos_position == SOS_LAST_POS) begin
         gap_ms = SOS_WORD_GAP_MS;
      end else begin
         gap_ms = SOS_GAP_MS;
      end
   end

   assign period_ms = (error_code == ERR_CODE_FAST) ? TOGGLE_FAST_MS : TOGGLE_SLOW_MS;

   // error mode: sos on led1, free toggle on led0
   always_comb begin
      sos_st                = state_cur;
      sos_st.phase_elapsed  = phase_inc;
      sos_st.toggle_elapsed = toggle_inc;
      if (state_cur.sos_lit_phase) begin
         sos_st.led1_level = 1'b1;
         if (phase_inc >= lit_ms) begin
            sos_st.led1_level    = 1'b0;
            sos_st.sos_lit_phase = 1'b0;
            sos_st.phase_elapsed = '0;
         end
      end else if (phase_inc >= gap_ms) begin
         sos_st.sos_position  = (state_cur.sos_position == SOS_LAST_POS) ?
                                4'd0 : 4'(state_cur.sos_position + 4'd1);
         sos_st.sos_lit_phase = 1'b1;
         sos_st.phase_elapsed = '0;
      end
      if (toggle_inc >= period_ms) begin
         sos_st.led0_level     = ~state_cur.led0_level;
         sos_st.toggle_elapsed = '0;
      end
   end

   always_comb begin
      state_nxt = state_cur;
      if (req.action == ACT_SET) begin
         state_nxt.current_mode   = req.mode;
         state_nxt.phase_elapsed  = '0;
         state_nxt.toggle_elapsed = '0;
         state_nxt.sos_position   = '0;
         state_nxt.sos_lit_phase  = 1'b1;
         state_nxt.led0_level     = 1'b0;
         state_nxt.led1_level     = 1'b0;
      end else begin
         state_nxt.phase_elapsed  = phase_inc;
         state_nxt.toggle_elapsed = toggle_inc;
         unique case (state_cur.current_mode) inside
            MODE_CHECK, MODE_UPGRADING: begin
               if (phase_inc >= on_ms) begin
                  state_nxt.led0_level = 1'b1;
                  if (phase_inc >= cycle_ms) begin
                     state_nxt.led0_level    = 1'b0;
                     state_nxt.phase_elapsed = '0;
                  end
               end
               state_nxt.led1_level = 1'b0;
            end
            MODE_DONE: begin
               state_nxt.led0_level = 1'b1;
               state_nxt.led1_level = 1'b0;
            end
            MODE_JUMP: begin
               state_nxt.led0_level = 1'b0;
               state_nxt.led1_level = 1'b0;
            end
            MODE_ERROR: begin
               state_nxt = sos_st;
            end
            default: begin
               state_nxt.led0_level = 1'b1;
               state_nxt.led1_level = 1'b1;
            end
         endcase
      end
   end

endmodule
`default_nettype wire
